@@ design/video_band_slice_splitter_top_assert.svh @@
// Assertion macros shared by the slice splitter modules.
// Each macro expands to one labeled concurrent assertion on clk.
`ifndef VIDEO_BAND_SLICE_SPLITTER_TOP_ASSERT_SVH
`define VIDEO_BAND_SLICE_SPLITTER_TOP_ASSERT_SVH

// Checked outside reset.
`define VBSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define VBSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/vbss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbss_pkg
// Types and constants of the band slice splitter.
// ----------------------------------------------------------------------------
package vbss_pkg;

    localparam int unsigned MAX_BAND_ROWS = 512;
    localparam int unsigned FRAME_ROWS    = 8192;

    localparam logic [31:0] LCG_MUL      = 32'd1664525;
    localparam logic [31:0] LCG_ADD      = 32'd1013904223;
    localparam logic [36:0] RAND_SPAN    = 37'd25;
    localparam logic [12:0] MIN_HEIGHT   = 13'd8;
    localparam logic [12:0] RESET_HEIGHT = 13'd16;

    localparam logic [1:0] CFG_FIXED_HEIGHT = 2'd0;
    localparam logic [1:0] CFG_RANDOM_MODE  = 2'd1;
    localparam logic [1:0] CFG_CHROMA_SHIFT = 2'd2;

    localparam logic OP_FRAME_START = 1'b0;
    localparam logic KIND_FRAME     = 1'b0;
    localparam logic KIND_SLICE     = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_HEIGHT = 4'b0010,
        ST_SLICE  = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    typedef struct packed {
        logic frame_accept;
        logic band_load;
        logic height_load;
        logic slice_load;
    } cmd_t;

    typedef struct packed {
        logic frame_item;
        logic band_skip;
        logic out_last;
    } status_t;

endpackage

@@ design/video_band_slice_splitter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_band_slice_splitter_top
// Cuts row bands into slices of a per-frame height chosen at frame start.
// ----------------------------------------------------------------------------
//  channel | signals                                      | dir
//  input   | in_valid in_stall opcode band_top band_rows   | in
//          | direction                                    |
//  output  | out_valid out_stall kind slice_top slice_rows | out
//          | slice_direction last                         |
//  config  | cfg_write cfg_index cfg_data                 | in
//
//  Frame start: accept, height compute, then emit of its single result.
//  Band: accept, cursor load, then one slice per cycle while the output is not stalled.
//  Empty, clipped-away or invalid-direction bands are dropped at accept and emit nothing.
//  The slice cursor adder and the output register set the one-slice-per-cycle rate.
//  Output stall holds the result register; no input word is taken until the run ends.
//  Reset is asynchronous and leaves the block idle with height 16.
// ----------------------------------------------------------------------------
module video_band_slice_splitter_top
    import vbss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [12:0] band_top,
    input  logic [9:0]  band_rows,
    input  logic [1:0]  direction,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [12:0] slice_top,
    output logic [12:0] slice_rows,
    output logic        slice_direction,
    output logic        last
);

    cmd_t    cmd;
    status_t status;

    vbss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    vbss_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .band_top        (band_top),
        .band_rows       (band_rows),
        .direction       (direction),
        .cmd             (cmd),
        .status          (status),
        .kind            (kind),
        .slice_top       (slice_top),
        .slice_rows      (slice_rows),
        .slice_direction (slice_direction),
        .last            (last)
    );

endmodule

@@ design/vbss_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbss_dp
// Datapath: config registers, LCG, slice height and band cursor.
// ----------------------------------------------------------------------------
module vbss_dp
    import vbss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        opcode,
    input  logic [12:0] band_top,
    input  logic [9:0]  band_rows,
    input  logic [1:0]  direction,
    input  cmd_t        cmd,
    output status_t     status,
    output logic        kind,
    output logic [12:0] slice_top,
    output logic [12:0] slice_rows,
    output logic        slice_direction,
    output logic        last
);

    `include "video_band_slice_splitter_top_assert.svh"

    logic [12:0] fixed_height_reg;
    logic        random_mode_reg;
    logic [1:0]  chroma_shift_reg;
    logic [31:0] lcg_reg;
    logic [31:0] lcg_next;
    logic [12:0] height_reg;

    logic [12:0] lo_reg;
    logic [12:0] lo_next;
    logic [9:0]  rem_reg;
    logic [9:0]  rem_next;
    logic        dir_reg;

    logic        kind_reg;
    logic [12:0] slice_top_reg;
    logic [12:0] slice_rows_reg;
    logic        slice_dir_reg;
    logic        last_reg;

    // band clipping
    logic [9:0]  rows_sat;
    logic [13:0] room;
    logic [9:0]  rows_clip;

    // height draw
    logic [36:0] scaled;
    logic [32:0] fold;
    logic [5:0]  quot;
    logic [12:0] raw_height;
    logic [12:0] align_mask;
    logic [12:0] aligned;
    logic [12:0] new_height;

    // slice cut
    logic        rem_gt_h;
    logic [9:0]  cut;
    logic [13:0] up_top;
    logic [12:0] cut_top;

    always_comb
    begin
        rows_sat  = (band_rows > 10'(MAX_BAND_ROWS)) ? 10'(MAX_BAND_ROWS) : band_rows;
        room      = 14'(FRAME_ROWS) - {1'b0, band_top};
        rows_clip = ({4'b0, rows_sat} > room) ? room[9:0] : rows_sat;
    end

    assign status.frame_item = (opcode == OP_FRAME_START);
    assign status.band_skip  = direction[1] | (rows_clip == 10'd0);
    assign status.out_last   = last_reg;

    assign lcg_next = 32'(lcg_reg * LCG_MUL) + LCG_ADD;

    // floor(x / (2^32-1)) for x < 25*2^32: high word plus a carry correction
    always_comb
    begin
        scaled     = {5'b0, lcg_reg} * RAND_SPAN;
        fold       = {28'b0, scaled[36:32]} + {1'b0, scaled[31:0]};
        quot       = {1'b0, scaled[36:32]} + 6'(fold >= 33'h0_FFFF_FFFF);
        raw_height = random_mode_reg ? (MIN_HEIGHT + 13'(quot)) : fixed_height_reg;
        align_mask = ~((13'd1 << chroma_shift_reg) - 13'd1);
        aligned    = raw_height & align_mask;
        new_height = (aligned < MIN_HEIGHT) ? MIN_HEIGHT : aligned;
    end

    always_comb
    begin
        rem_gt_h = ({3'b0, rem_reg} > height_reg);
        cut      = rem_gt_h ? height_reg[9:0] : rem_reg;
        up_top   = {1'b0, lo_reg} + 14'(rem_reg) - 14'(cut);
        cut_top  = dir_reg ? up_top[12:0] : lo_reg;
        rem_next = rem_reg - cut;
        lo_next  = dir_reg ? lo_reg : 13'(lo_reg + 13'(cut));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_height_reg <= RESET_HEIGHT;
            random_mode_reg  <= 1'b0;
            chroma_shift_reg <= 2'd0;
            lcg_reg          <= 32'd0;
            height_reg       <= RESET_HEIGHT;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_FIXED_HEIGHT: fixed_height_reg <= cfg_data;
                    CFG_RANDOM_MODE:  random_mode_reg  <= cfg_data[0];
                    CFG_CHROMA_SHIFT: chroma_shift_reg <= cfg_data[1:0];
                    default:          ;
                endcase
            end
            if (cmd.frame_accept && random_mode_reg)
            begin
                lcg_reg <= lcg_next;
            end
            if (cmd.height_load)
            begin
                height_reg <= new_height;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.band_load)
        begin
            lo_reg  <= band_top;
            rem_reg <= rows_clip;
            dir_reg <= direction[0];
        end
        else if (cmd.slice_load)
        begin
            lo_reg  <= lo_next;
            rem_reg <= rem_next;
        end

        if (cmd.height_load)
        begin
            kind_reg       <= KIND_FRAME;
            slice_top_reg  <= 13'd0;
            slice_rows_reg <= new_height;
            slice_dir_reg  <= 1'b0;
            last_reg       <= 1'b1;
        end
        else if (cmd.slice_load)
        begin
            kind_reg       <= KIND_SLICE;
            slice_top_reg  <= cut_top;
            slice_rows_reg <= 13'(cut);
            slice_dir_reg  <= dir_reg;
            last_reg       <= !rem_gt_h;
        end
    end

    assign kind            = kind_reg;
    assign slice_top       = slice_top_reg;
    assign slice_rows      = slice_rows_reg;
    assign slice_direction = slice_dir_reg;
    assign last            = last_reg;

    `VBSS_ASSERT(a_last_drains, (cmd.slice_load && !rem_gt_h) |=> (rem_reg == 10'd0), "last slice left rows behind")
    `VBSS_ASSERT(a_more_rows, (cmd.slice_load && rem_gt_h) |=> (rem_reg != 10'd0), "non-last slice emptied the band")

endmodule

@@ design/vbss_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbss_ctrl
// Sequencer: accepts one input word, then runs its results out.
// ----------------------------------------------------------------------------
module vbss_ctrl
    import vbss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    `include "video_band_slice_splitter_top_assert.svh"

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (status.frame_item)
                    begin
                        cmd.frame_accept = 1'b1;
                        state_next       = ST_HEIGHT;
                    end
                    else if (!status.band_skip)
                    begin
                        cmd.band_load = 1'b1;
                        state_next    = ST_SLICE;
                    end
                end
            end
            ST_HEIGHT:
            begin
                cmd.height_load = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_SLICE:
            begin
                cmd.slice_load = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (status.out_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // advance to the next slice while handing this one off
                        cmd.slice_load = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `VBSS_ASSERT(a_emit_hold, (state_reg == ST_EMIT && out_stall) |=> (state_reg == ST_EMIT), "result dropped under stall")
    `VBSS_ASSERT(a_frame_seq, (in_valid && !in_stall && status.frame_item) |=> (state_reg == ST_HEIGHT) ##1 (state_reg == ST_EMIT), "frame start did not reach output")
    `VBSS_ASSERT(a_last_idle, (out_valid && !out_stall && status.out_last) |=> !in_stall, "run did not end on last word")
    `VBSS_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !out_valid, "result offered during reset")

endmodule

@@ test/tb_video_band_slice_splitter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_video_band_slice_splitter_top
// Drives frame-start and band words into the slice splitter under random
// idling on both channels, predicts every slice word and its height choice,
// and checks each output word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_video_band_slice_splitter_top;
    import vbss_pkg::*;

    localparam logic       OP_BAND     = 1'b1;
    localparam logic [1:0] DIR_DOWN    = 2'd0;
    localparam logic [1:0] DIR_UP      = 2'd1;
    localparam logic [1:0] DIR_BAD     = 2'd2;
    localparam logic [1:0] DIR_BAD_HI  = 2'd3;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;

    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned HOLD_AT_WORD    = 300;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned RANDOM_PHASES   = 7;
    localparam int unsigned PHASE_ITEMS     = 42;

    typedef struct packed {
        logic        kind;
        logic [12:0] top;
        logic [12:0] rows;
        logic        dir;
        logic        last;
    } slice_word_t;

    class slice_scoreboard;
        localparam logic [31:0] STEP_MUL   = 32'd1664525;
        localparam logic [31:0] STEP_ADD   = 32'd1013904223;
        localparam int unsigned HEIGHT_MIN = 8;
        localparam int unsigned BAND_MAX   = 512;
        localparam int unsigned ROW_LIMIT  = 8192;
        localparam int unsigned SLICE_MAX  = 64;

        logic [12:0] fixed_height;
        logic        rand_on;
        logic [1:0]  chroma_shift;
        logic [31:0] rng_word;
        logic [12:0] cur_height;
        slice_word_t pending_slices[$];
        int unsigned errors;

        function new();
            fixed_height = 13'd16;
            rand_on      = 1'b0;
            chroma_shift = 2'd0;
            rng_word     = 32'd0;
            cur_height   = 13'd16;
            errors       = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [12:0] data);
            case (idx)
                CFG_FIXED_HEIGHT: fixed_height = data;
                CFG_RANDOM_MODE:  rand_on = data[0];
                CFG_CHROMA_SHIFT: chroma_shift = data[1:0];
                default: ;
            endcase
        endfunction

        function void add_slice(logic kind, int unsigned top, int unsigned rows, logic dir,
                                logic last);
            slice_word_t w;
            w.kind = kind;
            w.top  = top[12:0];
            w.rows = rows[12:0];
            w.dir  = dir;
            w.last = last;
            pending_slices.push_back(w);
        endfunction

        function void take_item(logic op, logic [12:0] top, logic [9:0] rows_in,
                                logic [1:0] dir);
            int unsigned h;
            int unsigned rows;
            int unsigned stop;
            int unsigned y;
            int unsigned n;
            longint unsigned scaled;
            if (op == OP_FRAME_START)
            begin
                if (rand_on)
                begin
                    rng_word = rng_word * STEP_MUL + STEP_ADD;
                    scaled = rng_word;
                    scaled = scaled * 25;
                    h = HEIGHT_MIN + int'(scaled / 64'hFFFF_FFFF);
                end
                else
                    h = fixed_height;
                h = h & ~((32'd1 << chroma_shift) - 32'd1);
                if (h < HEIGHT_MIN)
                    h = HEIGHT_MIN;
                cur_height = h[12:0];
                add_slice(KIND_FRAME, 0, cur_height, 1'b0, 1'b1);
                return;
            end
            if (dir > DIR_UP)
                return;
            rows = (rows_in > BAND_MAX) ? BAND_MAX : rows_in;
            if (top + rows > ROW_LIMIT)
                rows = ROW_LIMIT - top;
            if (rows == 0)
                return;
            h = cur_height;
            if (h < HEIGHT_MIN)
                h = HEIGHT_MIN;
            stop = top + rows;
            n = 0;
            if (dir == DIR_DOWN)
            begin
                for (y = top; y + h <= stop && n < SLICE_MAX; y += h)
                begin
                    add_slice(KIND_SLICE, y, h, 1'b0, 1'b0);
                    n++;
                end
                if (y < stop && n < SLICE_MAX)
                begin
                    add_slice(KIND_SLICE, y, stop - y, 1'b0, 1'b0);
                    n++;
                end
            end
            else
            begin
                // walk up from the bottom; the remainder holds the top rows
                for (y = stop; y >= top + h && n < SLICE_MAX; y -= h)
                begin
                    add_slice(KIND_SLICE, y - h, h, 1'b1, 1'b0);
                    n++;
                end
                if (y > top && n < SLICE_MAX)
                begin
                    add_slice(KIND_SLICE, top, y - top, 1'b1, 1'b0);
                    n++;
                end
            end
            if (n > 0)
                pending_slices[pending_slices.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned seen);
            if (want != seen)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, seen);
            end
        endfunction

        function void check_slice(logic kind, logic [12:0] top, logic [12:0] rows,
                                  logic dir, logic last);
            slice_word_t want;
            if (pending_slices.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual kind %0d top %0d rows %0d",
                         $time, kind, top, rows);
                return;
            end
            want = pending_slices.pop_front();
            compare_field("kind", want.kind, kind);
            compare_field("slice_top", want.top, top);
            compare_field("slice_rows", want.rows, rows);
            compare_field("slice_direction", want.dir, dir);
            compare_field("last", want.last, last);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [12:0] cfg_data = 13'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = 1'b0;
    logic [12:0] band_top = 13'd0;
    logic [9:0]  band_rows = 10'd0;
    logic [1:0]  direction = 2'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        kind;
    logic [12:0] slice_top;
    logic [12:0] slice_rows;
    logic        slice_direction;
    logic        last;

    logic calm = 1'b0;
    slice_scoreboard board = new();

    video_band_slice_splitter_top DUT (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.take_item(opcode, band_top, band_rows, direction);
        if (rst_n && out_valid && !out_stall)
            board.check_slice(kind, slice_top, slice_rows, slice_direction, last);
    end

    // output side: random stall per word, one long hold-off to back up the input
    initial
    begin : slice_sink
        int unsigned pause;
        int unsigned words;
        words = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (words == HOLD_AT_WORD)
                pause = HOLD_OFF_CYCLES;
            else
                pause = calm ? 0 : $urandom_range(0, 9);
            if (pause > 0)
            begin
                out_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            words++;
        end
    end

    task automatic send_word(input logic op, input logic [12:0] top, input logic [9:0] rows,
                             input logic [1:0] dir);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        band_top  <= top;
        band_rows <= rows;
        direction <= dir;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.set_reg(idx, data);
    endtask

    task automatic set_config(input logic [12:0] fixed, input logic rnd,
                              input logic [1:0] shift);
        logic [12:0] data;
        write_reg(CFG_FIXED_HEIGHT, fixed);
        // junk in the upper bits must be ignored
        data = 13'($urandom);
        data[0] = rnd;
        write_reg(CFG_RANDOM_MODE, data);
        data = 13'($urandom);
        data[1:0] = shift;
        write_reg(CFG_CHROMA_SHIFT, data);
        write_reg(CFG_UNUSED, 13'($urandom));
        cfg_write <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_slices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_word(output bit productive);
        logic        op;
        logic [12:0] top;
        logic [9:0]  rows;
        logic [1:0]  dir;
        op = ($urandom_range(0, 5) == 0) ? OP_FRAME_START : OP_BAND;
        case ($urandom_range(0, 9))
            0:       top = 13'($urandom_range(7680, 8191));
            1:       top = 13'($urandom);
            default: top = 13'($urandom_range(0, 4095));
        endcase
        case ($urandom_range(0, 9))
            0:       rows = 10'($urandom);
            1:       rows = 10'($urandom_range(513, 1023));
            2:       rows = 10'd0;
            3, 4:    rows = 10'($urandom_range(200, 512));
            default: rows = 10'($urandom_range(1, 120));
        endcase
        if ($urandom_range(0, 9) == 0)
            dir = $urandom_range(0, 1) ? DIR_BAD_HI : DIR_BAD;
        else
            dir = $urandom_range(0, 1) ? DIR_UP : DIR_DOWN;
        productive = (op == OP_FRAME_START) || (dir <= DIR_UP && rows != 0);
        send_word(op, top, rows, dir);
    endtask

    initial
    begin : stimulus
        int unsigned done;
        int unsigned tried;
        bit productive;
        logic [12:0] fixed;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(13'd13, 1'b0, 2'd2);
        // band before any frame start uses the reset height
        send_word(OP_BAND, 13'd0, 10'd40, DIR_DOWN);
        // frame start ignores the other fields
        send_word(OP_FRAME_START, 13'd8191, 10'd1023, DIR_BAD_HI);
        send_word(OP_BAND, 13'd0, 10'd0, DIR_DOWN);
        send_word(OP_BAND, 13'd5, 10'd1023, DIR_DOWN);
        send_word(OP_BAND, 13'd8191, 10'd512, DIR_UP);
        send_word(OP_BAND, 13'd8000, 10'd300, DIR_DOWN);
        send_word(OP_BAND, 13'd8191, 10'd0, DIR_UP);
        send_word(OP_BAND, 13'd64, 10'd100, DIR_BAD);
        send_word(OP_BAND, 13'd64, 10'd100, DIR_BAD_HI);
        send_word(OP_BAND, 13'd7, 10'd36, DIR_UP);
        send_word(OP_BAND, 13'd7, 10'd37, DIR_UP);
        send_word(OP_BAND, 13'd0, 10'd11, DIR_DOWN);
        drain();

        set_config(13'd0, 1'b0, 2'd3);
        send_word(OP_FRAME_START, 13'd0, 10'd0, DIR_DOWN);
        send_word(OP_BAND, 13'd0, 10'd512, DIR_DOWN);
        send_word(OP_BAND, 13'd7680, 10'd512, DIR_UP);
        drain();

        set_config(13'd8191, 1'b0, 2'd0);
        send_word(OP_FRAME_START, 13'd0, 10'd0, DIR_DOWN);
        send_word(OP_BAND, 13'd100, 10'd512, DIR_UP);
        drain();

        set_config(13'd8191, 1'b1, 2'd3);
        send_word(OP_FRAME_START, 13'd0, 10'd0, DIR_DOWN);
        send_word(OP_FRAME_START, 13'd0, 10'd0, DIR_DOWN);
        send_word(OP_FRAME_START, 13'd0, 10'd0, DIR_DOWN);
        send_word(OP_BAND, 13'd1000, 10'd200, DIR_DOWN);
        send_word(OP_FRAME_START, 13'd0, 10'd0, DIR_DOWN);
        send_word(OP_BAND, 13'd1000, 10'd200, DIR_UP);
        drain();

        set_config(13'd0, 1'b1, 2'd0);
        send_word(OP_FRAME_START, 13'd0, 10'd0, DIR_DOWN);
        send_word(OP_BAND, 13'd300, 10'd100, DIR_DOWN);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(0, 3))
                0:       fixed = 13'($urandom_range(0, 15));
                3:       fixed = 13'($urandom_range(0, 8191));
                default: fixed = 13'($urandom_range(8, 48));
            endcase
            set_config(fixed, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            done = 0;
            tried = 0;
            while (done < PHASE_ITEMS)
            begin
                // alternate between idling and back-to-back stretches
                if (tried % 32 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                random_word(productive);
                tried++;
                if (productive)
                    done++;
            end
            calm = 1'b0;
            drain();
        end

        if (board.errors == 0 && board.pending_slices.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
